[hdl/ams_pkg.sv]
// Shared types, constants and melody tables for the alarm melody sequencer.
package ams_pkg;

  localparam int TIME_WIDTH = 32;

  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_TONE    = 2'd1;
  localparam logic [1:0] CMD_SILENCE = 2'd2;

  localparam logic [1:0] PATTERN_NONE = 2'd3;
  localparam logic [1:0] PATTERN_MAX  = 2'd2;

  localparam logic [3:0]  LEVEL_RESET   = 4'd5;
  localparam logic [11:0] PITCH_FLOOR   = 12'd50;
  localparam logic [9:0]  SILENCE_LEAD  = 10'd10;

  typedef logic [TIME_WIDTH-1:0] time_t;

  // Control and status passed from the sequencer to the pitch unit.
  typedef struct packed {
    logic [1:0] pattern;
    logic [3:0] index;
    logic [3:0] level;
  } pitch_req_t;

  function automatic logic [3:0] melody_len(input logic [1:0] pat);
    case (pat)
      2'd0:    melody_len = 4'd10;
      2'd1:    melody_len = 4'd8;
      2'd2:    melody_len = 4'd7;
      default: melody_len = 4'd7;
    endcase
  endfunction

  function automatic logic [11:0] note_pitch(input logic [1:0] pat, input logic [3:0] idx);
    case ({pat, idx})
      6'h00: note_pitch = 12'd262;
      6'h01: note_pitch = 12'd330;
      6'h02: note_pitch = 12'd392;
      6'h03: note_pitch = 12'd440;
      6'h04: note_pitch = 12'd523;
      6'h05: note_pitch = 12'd523;
      6'h06: note_pitch = 12'd440;
      6'h07: note_pitch = 12'd392;
      6'h08: note_pitch = 12'd330;
      6'h09: note_pitch = 12'd262;
      6'h10: note_pitch = 12'd880;
      6'h11: note_pitch = 12'd1318;
      6'h12: note_pitch = 12'd1760;
      6'h13: note_pitch = 12'd1318;
      6'h14: note_pitch = 12'd880;
      6'h15: note_pitch = 12'd1318;
      6'h16: note_pitch = 12'd1760;
      6'h17: note_pitch = 12'd1318;
      6'h20: note_pitch = 12'd1500;
      6'h21: note_pitch = 12'd1200;
      6'h22: note_pitch = 12'd1500;
      6'h23: note_pitch = 12'd1200;
      6'h24: note_pitch = 12'd2000;
      6'h25: note_pitch = 12'd2000;
      6'h26: note_pitch = 12'd1000;
      default: note_pitch = 12'd0;
    endcase
  endfunction

  function automatic logic [9:0] note_dur(input logic [1:0] pat, input logic [3:0] idx);
    case ({pat, idx})
      6'h00, 6'h01, 6'h02, 6'h03: note_dur = 10'd300;
      6'h04:                      note_dur = 10'd600;
      6'h05, 6'h06, 6'h07, 6'h08: note_dur = 10'd300;
      6'h09:                      note_dur = 10'd1000;
      6'h10, 6'h11, 6'h12, 6'h13,
      6'h14, 6'h15, 6'h16:        note_dur = 10'd100;
      6'h17:                      note_dur = 10'd300;
      6'h20, 6'h21, 6'h22, 6'h23: note_dur = 10'd150;
      6'h24, 6'h25:               note_dur = 10'd200;
      6'h26:                      note_dur = 10'd500;
      default:                    note_dur = 10'd0;
    endcase
  endfunction

endpackage

[hdl/ams_if.sv]
// Valid/ready channel interfaces for the input and result transactions.
interface ams_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;
  logic [2:0]  pattern_select;
  logic        stop;

  modport source (output valid, time_ms, pattern_select, stop, input ready);
  modport sink   (input valid, time_ms, pattern_select, stop, output ready);
endinterface

interface ams_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] pitch_hz;

  modport source (output valid, command, pitch_hz, input ready);
  modport sink   (input valid, command, pitch_hz, output ready);
endinterface

[hdl/ams_pitch_shift.sv]
// Note pitch lookup with the sound level offset and the low frequency floor.
module ams_pitch_shift
  import ams_pkg::*;
(
  input  pitch_req_t  req,
  output logic [11:0] pitch_hz
);

  logic [12:0] base;
  logic [12:0] sum;

  // pitch + (level - 5) * 50 is formed as pitch + level * 50 - 250 to stay unsigned.
  always_comb begin
    base = {1'b0, note_pitch(req.pattern, req.index)};
    sum  = base + 13'(req.level) * 13'd50;
    if (sum < 13'd300) begin
      pitch_hz = PITCH_FLOOR;
    end else begin
      pitch_hz = 12'(sum - 13'd250);
    end
  end

endmodule

[hdl/ams_seq_core.sv]
// Melody sequencer: input register, note state, command logic and result register.
module ams_seq_core
  import ams_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] sound_level,
  ams_in_if.sink     in_ch,
  ams_out_if.source  out_ch
);

  logic        s1_valid_r;
  logic [31:0] s1_time_r;
  logic [2:0]  s1_pat_r;
  logic        s1_stop_r;

  logic        out_valid_r;
  logic [1:0]  out_cmd_r;
  logic [11:0] out_pitch_r;

  logic [1:0]  last_pattern_r, last_pattern_nxt;
  logic [3:0]  note_index_r, note_index_nxt;
  time_t       note_start_r, note_start_nxt;
  logic        note_playing_r, note_playing_nxt;

  logic        move;
  logic [1:0]  pat_c;
  logic        changed;
  logic [3:0]  idx0, idx1, idx_inc, idx2;
  time_t       now, start0, elapsed, dur, warn;
  logic        playing0, expired;
  logic [1:0]  cmd_nxt;
  logic [11:0] pitch_nxt;
  logic [11:0] shifted_pitch;
  pitch_req_t  preq;

  assign move        = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || move;

  always_comb begin
    pat_c    = (s1_pat_r > 3'(PATTERN_MAX)) ? PATTERN_MAX : s1_pat_r[1:0];
    now      = TIME_WIDTH'(s1_time_r);
    changed  = (pat_c != last_pattern_r);
    idx0     = changed ? 4'd0 : note_index_r;
    start0   = changed ? now : note_start_r;
    playing0 = changed ? 1'b0 : note_playing_r;
    idx1     = (idx0 >= melody_len(pat_c)) ? 4'd0 : idx0;
    dur      = TIME_WIDTH'(note_dur(pat_c, idx1));
    warn     = dur - TIME_WIDTH'(SILENCE_LEAD);
    elapsed  = now - start0;
    expired  = (elapsed >= dur);
    idx_inc  = idx1 + 4'd1;
    if (idx_inc >= melody_len(pat_c)) begin
      idx_inc = 4'd0;
    end
    idx2 = expired ? idx_inc : idx1;
  end

  assign preq.pattern = pat_c;
  assign preq.index   = idx2;
  assign preq.level   = sound_level;

  ams_pitch_shift u_pitch (
    .req      (preq),
    .pitch_hz (shifted_pitch)
  );

  always_comb begin
    last_pattern_nxt = last_pattern_r;
    note_index_nxt   = note_index_r;
    note_start_nxt   = note_start_r;
    note_playing_nxt = note_playing_r;
    cmd_nxt          = CMD_NONE;
    pitch_nxt        = 12'd0;
    if (s1_stop_r) begin
      last_pattern_nxt = PATTERN_NONE;
      cmd_nxt          = CMD_SILENCE;
    end else begin
      last_pattern_nxt = pat_c;
      note_index_nxt   = idx2;
      note_start_nxt   = expired ? now : start0;
      note_playing_nxt = 1'b1;
      // An expired or freshly selected note always starts a new tone.
      if (expired || !playing0) begin
        cmd_nxt   = CMD_TONE;
        pitch_nxt = shifted_pitch;
      end else if (elapsed >= warn) begin
        cmd_nxt = CMD_SILENCE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      last_pattern_r <= PATTERN_NONE;
      note_index_r   <= 4'd0;
      note_start_r   <= '0;
      note_playing_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (move) begin
        out_valid_r    <= 1'b1;
        last_pattern_r <= last_pattern_nxt;
        note_index_r   <= note_index_nxt;
        note_start_r   <= note_start_nxt;
        note_playing_r <= note_playing_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_time_r <= in_ch.time_ms;
      s1_pat_r  <= in_ch.pattern_select;
      s1_stop_r <= in_ch.stop;
    end
    if (move) begin
      out_cmd_r   <= cmd_nxt;
      out_pitch_r <= pitch_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.command  = out_cmd_r;
  assign out_ch.pitch_hz = out_pitch_r;

`ifndef ASSERT_OFF
  a_tone_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cmd_r == CMD_TONE |-> out_pitch_r >= PITCH_FLOOR)
    else $error("tone pitch below floor");

  a_pitch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cmd_r != CMD_TONE |-> out_pitch_r == 12'd0)
    else $error("pitch nonzero without tone command");

  a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid_r)
    else $error("result register not filled after transfer");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    last_pattern_r != PATTERN_NONE |-> note_index_r < melody_len(last_pattern_r))
    else $error("note index beyond melody");

  a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cmd_r <= CMD_SILENCE)
    else $error("undefined command code");
`endif

endmodule

[hdl/alarm_melody_sequencer_unit.sv]
// Top level of the alarm melody sequencer: sound level register and sequencer core.
//
// Usage: each input transaction on in_ch carries a millisecond timestamp, a
// melody select (0..2, larger values play melody 2) and a stop flag. Every
// input transaction produces exactly one result transaction on out_ch with a
// command (none, start tone, silence) and the tone pitch in hertz.
// cfg_we writes cfg_wdata into the sound level register, which shifts pitch
// by 50 Hz per step around level 5; write it only while the block is idle.
// Each input transaction passes one input register and then one result register,
// with the note ROM, elapsed time compare and pitch offset add between them.
// Throughput is one transaction per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; after that in_ch.ready drops until the
// result is taken. Reset (rst_n low, synchronous) forgets the melody, clears
// the note state, empties both registers and sets the sound level to 5.
module alarm_melody_sequencer_unit
  import ams_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  ams_in_if.sink     in_ch,
  ams_out_if.source  out_ch
);

  logic [3:0] sound_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sound_level_r <= LEVEL_RESET;
    end else if (cfg_we) begin
      sound_level_r <= cfg_wdata;
    end
  end

  ams_seq_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .sound_level (sound_level_r),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

endmodule

[bench/alarm_melody_sequencer_unit_tb.sv]
// Self-checking testbench for the alarm melody sequencer unit with random handshake stalls.
`timescale 1ns / 100ps

module alarm_melody_sequencer_unit_tb
  import ams_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HZ_PER_LEVEL = 50;
  localparam int PHASE_ITEMS  = 64;
  localparam int LEVEL_RANDOM = 16;

  // Sound levels for the random phases; LEVEL_RANDOM picks one at run time.
  localparam int LEVEL_PLAN [7] = '{0, 15, 10, 1, 11, LEVEL_RANDOM, 5};

  localparam int MELODY_NOTES [3] = '{10, 8, 7};
  localparam int MELODY_HZ [3][10] = '{
    '{262, 330, 392, 440, 523, 523, 440, 392, 330, 262},
    '{880, 1318, 1760, 1318, 880, 1318, 1760, 1318, 0, 0},
    '{1500, 1200, 1500, 1200, 2000, 2000, 1000, 0, 0, 0}
  };
  localparam int MELODY_MS [3][10] = '{
    '{300, 300, 300, 300, 600, 300, 300, 300, 300, 1000},
    '{100, 100, 100, 100, 100, 100, 100, 300, 0, 0},
    '{150, 150, 150, 150, 200, 200, 500, 0, 0, 0}
  };

  typedef struct packed {
    logic [31:0] time_ms;
    logic [2:0]  pattern_select;
    logic        stop;
  } melody_req_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] pitch_hz;
  } tone_cmd_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  ams_in_if  in_ch ();
  ams_out_if out_ch ();

  alarm_melody_sequencer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  melody_req_t req_q [$];
  tone_cmd_t   tone_cmd_q [$];

  int   queued_cnt;
  int   taken_cnt;
  int   err_count;
  int   cycle_cnt;
  logic req_taken;
  bit   quiet;
  int   src_hold;
  int   snk_hold;

  // Predicted sequencer state and the sound level register.
  logic [1:0] cur_pat;
  logic [3:0] note_idx;
  time_t      note_t0;
  logic       sounding;
  logic [3:0] level_q;

  // Timeline of the random stimulus.
  time_t      walk_t;
  logic [2:0] walk_sel;

  always #5 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
    err_count++;
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic sequence_note(input melody_req_t req, output tone_cmd_t res);
    logic [1:0] pat;
    time_t      elapsed;
    int         dur;
    int         hz;
    res.command  = CMD_NONE;
    res.pitch_hz = '0;
    if (req.stop) begin
      cur_pat     = PATTERN_NONE;
      res.command = CMD_SILENCE;
    end else begin
      pat = (req.pattern_select > 3'(PATTERN_MAX)) ? PATTERN_MAX : req.pattern_select[1:0];
      if (pat != cur_pat) begin
        cur_pat  = pat;
        note_idx = '0;
        note_t0  = req.time_ms;
        sounding = 1'b0;
      end
      if (note_idx >= MELODY_NOTES[pat]) note_idx = '0;
      dur     = MELODY_MS[pat][note_idx];
      elapsed = req.time_ms - note_t0;
      if (elapsed >= time_t'(dur)) begin
        note_idx = note_idx + 4'd1;
        if (note_idx >= MELODY_NOTES[pat]) note_idx = '0;
        note_t0  = req.time_ms;
        sounding = 1'b0;
      end
      if (!sounding) begin
        hz = MELODY_HZ[pat][note_idx] + (int'(level_q) - int'(LEVEL_RESET)) * HZ_PER_LEVEL;
        if (hz < int'(PITCH_FLOOR)) hz = int'(PITCH_FLOOR);
        res.command  = CMD_TONE;
        res.pitch_hz = hz[11:0];
        sounding     = 1'b1;
      end else if (elapsed >= time_t'(dur - int'(SILENCE_LEAD))) begin
        res.command = CMD_SILENCE;
      end
    end
  endtask

  // Sampling, prediction and checking at the rising edge.
  always @(posedge clk) begin
    tone_cmd_t got;
    tone_cmd_t want;
    melody_req_t req;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("alarm_melody_sequencer_unit_tb: done, errors");
      $finish;
    end else if (!rst_n) begin
      cur_pat   = PATTERN_NONE;
      note_idx  = '0;
      note_t0   = '0;
      sounding  = 1'b0;
      level_q   = LEVEL_RESET;
      req_taken <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.command  = out_ch.command;
        got.pitch_hz = out_ch.pitch_hz;
        if (tone_cmd_q.size() == 0) begin
          flag_error($sformatf("unexpected result cmd=%0d pitch=%0d",
                               got.command, got.pitch_hz));
        end else begin
          want = tone_cmd_q.pop_front();
          if (got.command != want.command)
            flag_error($sformatf("command %0d, expected %0d", got.command, want.command));
          if (got.pitch_hz != want.pitch_hz)
            flag_error($sformatf("pitch_hz %0d, expected %0d", got.pitch_hz, want.pitch_hz));
        end
      end
      if (cfg_we) level_q = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        req.time_ms        = in_ch.time_ms;
        req.pattern_select = in_ch.pattern_select;
        req.stop           = in_ch.stop;
        sequence_note(req, want);
        tone_cmd_q.push_back(want);
        taken_cnt++;
      end
      req_taken <= in_ch.valid && in_ch.ready;
    end
  end

  // Input driver: presents the next pending item once the previous transaction completes.
  always @(negedge clk) begin
    melody_req_t req;
    if (!rst_n) begin
      in_ch.valid          <= 1'b0;
      in_ch.time_ms        <= '0;
      in_ch.pattern_select <= '0;
      in_ch.stop           <= 1'b0;
      src_hold = 0;
    end else if (!in_ch.valid || req_taken) begin
      if (src_hold > 0) begin
        src_hold--;
        in_ch.valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        req = req_q.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.time_ms        <= req.time_ms;
        in_ch.pattern_select <= req.pattern_select;
        in_ch.stop           <= req.stop;
        src_hold = draw_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink with random stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_hold = 0;
    end else begin
      if (snk_hold > 0) begin
        snk_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        snk_hold = draw_gap();
      end
    end
  end

  task automatic add_item(input time_t t, input logic [2:0] sel, input logic stp);
    melody_req_t req;
    req.time_ms        = t;
    req.pattern_select = sel;
    req.stop           = stp;
    req_q.push_back(req);
    queued_cnt++;
  endtask

  // Mostly a steadily advancing clock on a held melody, with jumps, wraps,
  // melody changes and stops mixed in.
  task automatic queue_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      walk_t = walk_t + $urandom_range(0, 12);
      else if (r < 75) walk_t = walk_t + $urandom_range(13, 160);
      else if (r < 92) walk_t = walk_t + $urandom_range(161, 1100);
      else if (r < 97) walk_t = $urandom;
      else             walk_t = 32'hFFFF_FFFF - $urandom_range(0, 600);
      if ($urandom_range(0, 99) < 4) walk_sel = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 3) add_item(walk_t, 3'($urandom_range(0, 7)), 1'b1);
      else add_item(walk_t, walk_sel, 1'b0);
    end
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || taken_cnt != queued_cnt || tone_cmd_q.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_level(input logic [3:0] lvl);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= lvl;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int lvl;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    rst_n                = 1'b0;
    queued_cnt           = 0;
    quiet                = 1'b0;
    walk_t               = '0;
    walk_sel             = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset level: note start, hold, silence lead-in,
    // advance, stop, melody change, clamped selects, a full melody 2 loop
    // and a timestamp wrap.
    add_item(32'd0, 3'd0, 1'b0);
    add_item(32'd5, 3'd0, 1'b0);
    add_item(32'd290, 3'd0, 1'b0);
    add_item(32'd300, 3'd0, 1'b0);
    add_item(32'd300, 3'd7, 1'b1);
    add_item(32'd301, 3'd1, 1'b0);
    add_item(32'd401, 3'd1, 1'b0);
    add_item(32'd410, 3'd5, 1'b0);
    add_item(32'd415, 3'd7, 1'b0);
    add_item(32'd550, 3'd3, 1'b0);
    add_item(32'd560, 3'd2, 1'b0);
    add_item(32'd710, 3'd6, 1'b0);
    add_item(32'd860, 3'd2, 1'b0);
    add_item(32'd1010, 3'd2, 1'b0);
    add_item(32'd1210, 3'd2, 1'b0);
    add_item(32'd1410, 3'd2, 1'b0);
    add_item(32'd1910, 3'd2, 1'b0);
    add_item(32'hFFFF_FFFF, 3'd0, 1'b1);
    add_item(32'hFFFF_FFF0, 3'd0, 1'b0);
    add_item(32'h0000_0100, 3'd0, 1'b0);
    add_item(32'h0000_0123, 3'd0, 1'b0);
    add_item(32'h0000_0123, 3'd4, 1'b1);
    wait_idle();

    walk_t = 32'h0000_0200;
    for (int ph = 0; ph < 7; ph++) begin
      lvl = LEVEL_PLAN[ph];
      if (lvl == LEVEL_RANDOM) lvl = $urandom_range(0, 15);
      write_level(lvl[3:0]);
      quiet = (ph == 2) || ($urandom_range(0, 4) == 0);
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (err_count == 0) begin
      $display("alarm_melody_sequencer_unit_tb: done, clean");
    end else begin
      $display("alarm_melody_sequencer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
